// ----- src/sequential_servo_pulse_scheduler_top_assert.svh -----
// Assertion macros for the servo pulse scheduler top level.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef SEQUENTIAL_SERVO_PULSE_SCHEDULER_TOP_ASSERT_SVH
`define SEQUENTIAL_SERVO_PULSE_SCHEDULER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SSPS_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("servo scheduler invariant violated");

// A condition that must hold in the cycle after a trigger.
`define SSPS_IMPLIES_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo scheduler sequence violated");

`endif

// ----- src/ssps_pkg.sv -----
// Shared types and constants of the servo pulse scheduler.
// Used by ssps_cmd, ssps_cell and the top level; depends on nothing else.
`default_nettype none

package ssps_pkg;

  localparam int unsigned ANGLE_W      = 8;
  localparam int unsigned WIDTH_W      = 12;
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned PIN_W        = 4;
  localparam int unsigned CFG_CHANNELS = 4;
  localparam int unsigned CHAN_W       = $clog2(CFG_CHANNELS);
  localparam int unsigned CFG_INDEX_W  = 4;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned FRAME_LENGTH_DEF = 40000;

  // Channel state after reset: centre angle and its pulse width.
  localparam logic [ANGLE_W-1:0] RESET_ANGLE = 8'd90;
  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 12'd3000;

  // Reset values of the per-channel angle limits.
  localparam logic [ANGLE_W-1:0] MIN_RESET [CFG_CHANNELS] = '{8'd30, 8'd20, 8'd80, 8'd40};
  localparam logic [ANGLE_W-1:0] MAX_RESET [CFG_CHANNELS] = '{8'd150, 8'd100, 8'd160, 8'd125};

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_ANGLE  = 2'd1,
    OP_SET_ENABLE = 2'd2,
    OP_QUERY      = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_CH0 = 4'd0,
    REG_MAX_CH0 = 4'd1,
    REG_MIN_CH1 = 4'd2,
    REG_MAX_CH1 = 4'd3,
    REG_MIN_CH2 = 4'd4,
    REG_MAX_CH2 = 4'd5,
    REG_MIN_CH3 = 4'd6,
    REG_MAX_CH3 = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [CHAN_W-1:0]   channel;
    logic [ANGLE_W-1:0]  angle;
    logic                enable;
  } item_t;

  typedef struct packed {
    logic [PIN_W-1:0]    pin_levels;
    logic [SLOT_W-1:0]   active_slot;
    logic [ANGLE_W-1:0]  angle_readback;
    logic                enabled_readback;
  } result_t;

  // Decoded command towards the channel cells.
  typedef struct packed {
    logic                set_angle;
    logic                set_enable;
    logic                enable;
    logic [CHAN_W-1:0]   channel;
    logic [ANGLE_W-1:0]  angle;
    logic [WIDTH_W-1:0]  width;
  } cmd_t;

  // Slot hand-over from one cell to the next.
  typedef struct packed {
    logic arrive;  // the running slot reaches this cell in this tick
    logic zero;    // every earlier slot of the new frame has zero width
  } link_t;

  // Per-cell state seen by the top level.
  typedef struct packed {
    logic                running;
    logic                pin;
    logic                running_next;
    logic                pin_next;
    logic                enabled_next;
    logic [ANGLE_W-1:0]  angle_next;
  } cell_stat_t;

endpackage

`default_nettype wire

// ----- src/ssps_cmd.sv -----
// Command decoder: angle limit registers, clamping and pulse width calculation.
// Depends on ssps_pkg.
`default_nettype none

module ssps_cmd #(
  parameter int unsigned NUM_CHANNELS = ssps_pkg::NUM_CHANNELS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire  [ssps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [ssps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                 item_take,
  input  ssps_pkg::item_t                     item,
  output ssps_pkg::cmd_t                      cmd
);
  import ssps_pkg::*;

  // 2000/180 scaled by 2^20 and raised above the exact value; exact floor for 8-bit angles.
  localparam logic [31:0] WIDTH_RECIP = 32'd11650900;
  localparam logic [WIDTH_W:0] WIDTH_BASE = 13'd2000;
  localparam logic [WIDTH_W:0] WIDTH_MAX  = 13'd4095;

  logic [ANGLE_W-1:0] min_angle [CFG_CHANNELS];
  logic [ANGLE_W-1:0] max_angle [CFG_CHANNELS];
  logic [ANGLE_W-1:0] lo_angle, hi_angle, raised, clamped;
  logic               present;

  function automatic logic [WIDTH_W-1:0] width_of(input logic [ANGLE_W-1:0] a);
    logic [31:0]      prod;
    logic [WIDTH_W:0] w;
    prod = 32'(a) * WIDTH_RECIP;
    w    = WIDTH_BASE + (WIDTH_W+1)'(prod[31:20]);
    return (w > WIDTH_MAX) ? WIDTH_MAX[WIDTH_W-1:0] : w[WIDTH_W-1:0];
  endfunction

  // Limit registers, written over the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle <= MIN_RESET;
      max_angle <= MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_CH0: min_angle[0] <= cfg_data;
        REG_MAX_CH0: max_angle[0] <= cfg_data;
        REG_MIN_CH1: min_angle[1] <= cfg_data;
        REG_MAX_CH1: max_angle[1] <= cfg_data;
        REG_MIN_CH2: min_angle[2] <= cfg_data;
        REG_MAX_CH2: max_angle[2] <= cfg_data;
        REG_MIN_CH3: min_angle[3] <= cfg_data;
        REG_MAX_CH3: max_angle[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Raise to the minimum first, then lower to the maximum, so the maximum wins.
  assign lo_angle = min_angle[item.channel];
  assign hi_angle = max_angle[item.channel];
  assign raised   = (item.angle < lo_angle) ? lo_angle : item.angle;
  assign clamped  = (raised > hi_angle) ? hi_angle : raised;
  assign present  = (int'(item.channel) < NUM_CHANNELS);

  // Commands to channels that do not exist are dropped here.
  always_comb begin
    cmd.set_angle  = item_take && present && (item.opcode == OP_SET_ANGLE);
    cmd.set_enable = item_take && present && (item.opcode == OP_SET_ENABLE);
    cmd.enable     = item.enable;
    cmd.channel    = item.channel;
    cmd.angle      = clamped;
    cmd.width      = width_of(clamped);
  end

endmodule

`default_nettype wire

// ----- src/ssps_cell.sv -----
// One channel cell of the slot chain: channel settings, latched slot and pin.
// Depends on ssps_pkg; cells are chained by the top level.
`default_nettype none

module ssps_cell #(
  parameter int unsigned END_W = 14
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            step,
  input  wire                            frame_start,
  input  wire  [ssps_pkg::COUNT_W-1:0]   counter,
  input  ssps_pkg::cmd_t                 cmd,
  input  wire                            sel,
  input  ssps_pkg::link_t                link_in,
  output ssps_pkg::link_t                link_out,
  input  wire  [END_W-1:0]               end_in,
  output logic [END_W-1:0]               end_out,
  output ssps_pkg::cell_stat_t           stat
);
  import ssps_pkg::*;

  logic               running, pin, enabled;
  logic [ANGLE_W-1:0] angle;
  logic [WIDTH_W-1:0] pulse_width, frame_width;
  logic [END_W-1:0]   slot_end;

  logic               running_next, pin_next, enabled_next;
  logic [ANGLE_W-1:0] angle_next;
  logic [WIDTH_W-1:0] pulse_width_next;
  logic [WIDTH_W-1:0] eff_width, use_width;
  logic               live, hit, pass, use_nz;

  // Width this slot takes if a frame starts now.
  assign eff_width     = enabled ? pulse_width : '0;
  assign link_out.zero = link_in.zero && (eff_width == '0);

  // At frame start the counter is zero, so the slot ends at once exactly when
  // it and all slots before it are empty; otherwise compare with the end time.
  assign hit = frame_start ? link_out.zero : (counter == COUNT_W'(slot_end));

  assign use_width       = frame_start ? eff_width : frame_width;
  assign use_nz          = (use_width != '0);
  assign live            = link_in.arrive || running;
  assign pass            = step && live && hit;
  assign link_out.arrive = pass;
  assign end_out         = slot_end;

  // Next state of the slot, the pin and the channel settings.
  always_comb begin
    running_next     = step ? (live && !hit) : running;
    pin_next         = pin;
    enabled_next     = enabled;
    angle_next       = angle;
    pulse_width_next = pulse_width;
    if (step) begin
      if (pass && use_nz) begin
        pin_next = 1'b0;
      end else if (link_in.arrive && use_nz) begin
        pin_next = 1'b1;
      end
    end
    if (sel && cmd.set_angle) begin
      angle_next       = cmd.angle;
      pulse_width_next = cmd.width;
      enabled_next     = 1'b1;
    end
    if (sel && cmd.set_enable) begin
      enabled_next = cmd.enable;
      if (!cmd.enable) begin
        pin_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      pin         <= 1'b0;
      enabled     <= 1'b1;
      angle       <= RESET_ANGLE;
      pulse_width <= RESET_WIDTH;
      frame_width <= '0;
      slot_end    <= '0;
    end else begin
      running     <= running_next;
      pin         <= pin_next;
      enabled     <= enabled_next;
      angle       <= angle_next;
      pulse_width <= pulse_width_next;
      if (step && frame_start) begin
        frame_width <= eff_width;
      end
      // Running end time ripples down the chain one cell per cycle.
      slot_end <= end_in + END_W'(frame_width);
    end
  end

  always_comb begin
    stat.running      = running;
    stat.pin          = pin;
    stat.running_next = running_next;
    stat.pin_next     = pin_next;
    stat.enabled_next = enabled_next;
    stat.angle_next   = angle_next;
  end

endmodule

`default_nettype wire

// ----- src/sequential_servo_pulse_scheduler_top.sv -----
// Servo pulse scheduler. Takes one beat per clock cycle on the item channel,
// whatever its opcode, and returns one result beat for each, registered, in the
// cycle after acceptance; the item side keeps accepting while a result waits
// as long as the result register is being emptied in the same cycle. Ticks
// advance a frame counter of FRAME_LENGTH ticks; at each frame start a chain of
// NUM_CHANNELS cells latches the enabled pulse widths and passes the running
// slot along the chain, raising each pin as its slot begins and dropping it at
// the slot end, with empty slots passing within the same tick. The slot end
// times are summed down the chain one cell per cycle, so they settle long
// before the shortest non-empty slot (2000 ticks) can end. Configuration
// writes are taken in every cycle.
// Depends on ssps_pkg, ssps_cmd, ssps_cell and the assertion macro header.
`default_nettype none

`include "sequential_servo_pulse_scheduler_top_assert.svh"

module sequential_servo_pulse_scheduler_top #(
  parameter int unsigned NUM_CHANNELS = ssps_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned FRAME_LENGTH = ssps_pkg::FRAME_LENGTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               item_valid,
  output logic                              item_ready,
  input  ssps_pkg::item_t                   item,
  output logic                              result_valid,
  input  wire                               result_ready,
  output ssps_pkg::result_t                 result,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [ssps_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [ssps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ssps_pkg::*;

  localparam int unsigned END_W = WIDTH_W + $clog2(NUM_CHANNELS);
  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(FRAME_LENGTH - 1);

  logic                take, step, frame_start, idle;
  logic [COUNT_W-1:0]  counter, counter_next;
  cmd_t                cmd;
  link_t               link [NUM_CHANNELS+1];
  logic [END_W-1:0]    ends [NUM_CHANNELS+1];
  cell_stat_t          stat [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]       running_vec, pin_vec, pin_next_vec;
  logic [PIN_W+NUM_CHANNELS-1:0] pin_pad;
  logic                present;
  result_t             result_next;

  // Handshakes: the result register frees itself in the cycle it is read.
  assign item_ready = !result_valid || result_ready;
  assign take       = item_valid && item_ready;
  assign step       = take && (item.opcode == OP_TICK);
  assign cfg_ready  = 1'b1;

  ssps_cmd #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_cmd (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_take (take),
    .item      (item),
    .cmd       (cmd)
  );

  // Frame counter, wrapping at the frame length.
  assign counter_next = (counter >= COUNT_LAST) ? '0 : counter + COUNT_W'(1);
  assign idle         = !(|running_vec);
  assign frame_start  = step && idle && (counter_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= COUNT_LAST;
    end else if (step) begin
      counter <= counter_next;
    end
  end

  // Chain of channel cells.
  assign link[0].arrive = frame_start;
  assign link[0].zero   = 1'b1;
  assign ends[0]        = '0;

  for (genvar j = 0; j < NUM_CHANNELS; j++) begin : g_cell
    ssps_cell #(
      .END_W (END_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .step        (step),
      .frame_start (frame_start),
      .counter     (counter_next),
      .cmd         (cmd),
      .sel         (int'(cmd.channel) == j),
      .link_in     (link[j]),
      .link_out    (link[j+1]),
      .end_in      (ends[j]),
      .end_out     (ends[j+1]),
      .stat        (stat[j])
    );
    assign running_vec[j]  = stat[j].running;
    assign pin_vec[j]      = stat[j].pin;
    assign pin_next_vec[j] = stat[j].pin_next;
  end

  // Result from the state after this item.
  assign present = (int'(item.channel) < NUM_CHANNELS);
  assign pin_pad = {PIN_W'(0), pin_next_vec};

  always_comb begin
    result_next.pin_levels       = pin_pad[PIN_W-1:0];
    result_next.active_slot      = SLOT_W'(NUM_CHANNELS);
    result_next.angle_readback   = '0;
    result_next.enabled_readback = 1'b0;
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      if (stat[j].running_next) begin
        result_next.active_slot = SLOT_W'(j);
      end
      if (present && (int'(item.channel) == j)) begin
        result_next.angle_readback   = stat[j].angle_next;
        result_next.enabled_readback = stat[j].enabled_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  // At most one slot runs at a time.
  `SSPS_ALWAYS(a_one_slot, $onehot0(running_vec))
  // A pin is only high while its own slot runs.
  `SSPS_ALWAYS(a_pin_in_slot, (pin_vec & ~running_vec) == '0)
  // The frame counter stays inside the frame.
  `SSPS_ALWAYS(a_counter_range, counter <= COUNT_LAST)
  // Every accepted item leaves a result beat waiting.
  `SSPS_IMPLIES_NEXT(a_result_follows, take, result_valid)

endmodule

`default_nettype wire

// ----- tb/tb_sequential_servo_pulse_scheduler_top.sv -----
// Self-checking testbench for the sequential servo pulse scheduler top level.
// Drives item and register beats, predicts every result beat internally and
// compares it field by field. Depends on ssps_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module tb_sequential_servo_pulse_scheduler_top;
  import ssps_pkg::*;

  localparam int unsigned NCH          = NUM_CHANNELS_DEF;
  localparam int unsigned FRAME        = FRAME_LENGTH_DEF;
  localparam int unsigned PULSE_MIN    = 2000;
  localparam int unsigned PULSE_SPAN   = 2000;
  localparam int unsigned DEGREES      = 180;
  localparam int unsigned WIDTH_LIMIT  = 4095;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int          TIMEOUT_NS   = 100_000_000;

  localparam cfg_reg_t MIN_REG [NCH] = '{REG_MIN_CH0, REG_MIN_CH1, REG_MIN_CH2, REG_MIN_CH3};
  localparam cfg_reg_t MAX_REG [NCH] = '{REG_MAX_CH0, REG_MAX_CH1, REG_MAX_CH2, REG_MAX_CH3};

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_ready;
  item_t                  item         = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  // Scheduler state as the testbench expects it to be.
  logic [ANGLE_W-1:0] lim_lo      [NCH];
  logic [ANGLE_W-1:0] lim_hi      [NCH];
  logic [ANGLE_W-1:0] ch_angle    [NCH];
  logic [WIDTH_W-1:0] ch_width    [NCH];
  bit                 ch_on       [NCH];
  logic [WIDTH_W-1:0] frame_w     [NCH];
  int unsigned        slot_end_at [NCH];
  int unsigned        tick_now;
  int unsigned        slot_now;
  logic [PIN_W-1:0]   pin_now;

  result_t     expected_results [$];
  int unsigned errors       = 0;
  bit          hold_pending = 1'b0;
  bit          send_calm    = 1'b0;
  int unsigned send_calm_left = 0;

  sequential_servo_pulse_scheduler_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pulse width of an angle, saturating at the largest value of the width field.
  function automatic logic [WIDTH_W-1:0] angle_to_width(input logic [ANGLE_W-1:0] a);
    int unsigned w;
    w = PULSE_MIN + (int'(a) * PULSE_SPAN) / DEGREES;
    if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
    return w[WIDTH_W-1:0];
  endfunction

  function automatic void reset_schedule();
    int unsigned c;
    for (c = 0; c < NCH; c++) begin
      lim_lo[c]      = MIN_RESET[c];
      lim_hi[c]      = MAX_RESET[c];
      ch_angle[c]    = RESET_ANGLE;
      ch_width[c]    = angle_to_width(RESET_ANGLE);
      ch_on[c]       = 1'b1;
      frame_w[c]     = '0;
      slot_end_at[c] = 0;
    end
    tick_now = FRAME - 1;
    slot_now = 0;
    pin_now  = '0;
  endfunction

  function automatic void apply_limit(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MIN_CH0: lim_lo[0] = data;
      REG_MAX_CH0: lim_hi[0] = data;
      REG_MIN_CH1: lim_lo[1] = data;
      REG_MAX_CH1: lim_hi[1] = data;
      REG_MIN_CH2: lim_lo[2] = data;
      REG_MAX_CH2: lim_hi[2] = data;
      REG_MIN_CH3: lim_lo[3] = data;
      REG_MAX_CH3: lim_hi[3] = data;
      default: ;
    endcase
  endfunction

  // One tick of the timebase: frame start, then every slot that ends now.
  // Empty slots end on the tick they begin, so several may pass in one tick.
  function automatic void advance_tick();
    int unsigned sum, i, n;
    bit done;
    tick_now = (tick_now >= FRAME - 1) ? 0 : tick_now + 1;
    if (slot_now > NCH) slot_now = 0;
    if (slot_now == 0 && tick_now == 0) begin
      sum = 0;
      for (i = 0; i < NCH; i++) begin
        frame_w[i]     = ch_on[i] ? ch_width[i] : '0;
        sum           += frame_w[i];
        slot_end_at[i] = sum;
      end
      if (frame_w[0] != 0) pin_now[0] = 1'b1;
      slot_now = 1;
    end
    done = 1'b0;
    for (n = 0; n <= NCH && !done; n++) begin
      if (slot_now == 0) begin
        done = 1'b1;
      end else if (tick_now != slot_end_at[slot_now - 1]) begin
        done = 1'b1;
      end else begin
        if (frame_w[slot_now - 1] != 0) pin_now[slot_now - 1] = 1'b0;
        if (slot_now < NCH) begin
          if (frame_w[slot_now] != 0) pin_now[slot_now] = 1'b1;
          slot_now++;
        end else begin
          slot_now = 0;
        end
      end
    end
  endfunction

  // Applies one accepted item to the expected state and returns its result.
  function automatic result_t schedule_step(input item_t it);
    result_t            r;
    int unsigned        ch;
    logic [ANGLE_W-1:0] ang;
    bit                 present;
    ch      = it.channel;
    present = ch < NCH;
    case (it.opcode)
      OP_TICK: advance_tick();
      OP_SET_ANGLE: begin
        if (present) begin
          ang = it.angle;
          if (ang < lim_lo[ch]) ang = lim_lo[ch];
          if (ang > lim_hi[ch]) ang = lim_hi[ch];
          ch_angle[ch] = ang;
          ch_width[ch] = angle_to_width(ang);
          ch_on[ch]    = 1'b1;
        end
      end
      OP_SET_ENABLE: begin
        if (present) begin
          ch_on[ch] = it.enable;
          if (!it.enable) pin_now[ch] = 1'b0;
        end
      end
      default: ;
    endcase
    r.pin_levels       = pin_now;
    r.active_slot      = SLOT_W'((slot_now == 0) ? NCH : slot_now - 1);
    r.angle_readback   = present ? ch_angle[ch] : '0;
    r.enabled_readback = present && ch_on[ch];
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 999);
    if (r < 700) return 0;
    if (r < 930) return $urandom_range(1, 3);
    if (r < 995) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t make_item(input opcode_t op, input logic [CHAN_W-1:0] ch,
                                      input logic [ANGLE_W-1:0] ang, input logic en);
    item_t it;
    it.opcode  = op;
    it.channel = ch;
    it.angle   = ang;
    it.enable  = en;
    return it;
  endfunction

  function automatic item_t random_item();
    int unsigned r;
    opcode_t     op;
    r = $urandom_range(0, 99);
    if (r < 40)      op = OP_TICK;
    else if (r < 65) op = OP_SET_ANGLE;
    else if (r < 85) op = OP_SET_ENABLE;
    else             op = OP_QUERY;
    return make_item(op, CHAN_W'($urandom_range(0, NCH - 1)),
                     ANGLE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  // A tick almost always, now and then a command landing inside the frame.
  function automatic item_t frame_item();
    if ($urandom_range(0, 127) == 0)
      return make_item(opcode_t'($urandom_range(1, 3)), CHAN_W'($urandom_range(0, NCH - 1)),
                       ANGLE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    return make_item(OP_TICK, CHAN_W'($urandom_range(0, NCH - 1)),
                     ANGLE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd180;
      2:       return 8'd255;
      default: return ANGLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one item beat; entered and left just after a falling edge.
  task automatic send_item(input item_t it);
    int unsigned gap;
    if (send_calm_left == 0) begin
      send_calm      = !send_calm;
      send_calm_left = $urandom_range(50, 500);
    end else begin
      send_calm_left--;
    end
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_results.push_back(schedule_step(it));
    @(negedge clk);
  endtask

  // Writes one register; cfg_valid is left high for a following write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_limit(idx, data);
    @(negedge clk);
  endtask

  task automatic write_limits(input logic [NCH-1:0][ANGLE_W-1:0] lo,
                              input logic [NCH-1:0][ANGLE_W-1:0] hi);
    int unsigned c;
    for (c = 0; c < NCH; c++) begin
      write_reg(MIN_REG[c], lo[c]);
      write_reg(MAX_REG[c], hi[c]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Stops offering items and waits until every result beat has come back.
  task automatic settle();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_state();
    int unsigned c;
    for (c = 0; c < NCH; c++)
      send_item(make_item(OP_QUERY, CHAN_W'(c), ANGLE_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1))));
  endtask

  // Clamping against the reset limits, enable handling and the first frame start.
  task automatic test_command_basics();
    send_item(make_item(OP_SET_ANGLE, 2'd0, 8'd0, 1'b0));
    send_item(make_item(OP_SET_ANGLE, 2'd1, 8'd255, 1'b1));
    send_item(make_item(OP_SET_ANGLE, 2'd2, 8'd180, 1'b0));
    send_item(make_item(OP_SET_ANGLE, 2'd3, 8'd60, 1'b0));
    send_item(make_item(OP_SET_ENABLE, 2'd1, 8'd0, 1'b0));
    send_item(make_item(OP_SET_ENABLE, 2'd1, 8'd0, 1'b1));
    send_item(make_item(OP_SET_ENABLE, 2'd3, 8'd255, 1'b0));
    send_item(make_item(OP_TICK, 2'd0, 8'd0, 1'b0));
    send_item(make_item(OP_TICK, 2'd3, 8'd255, 1'b1));
    // Dropping the enable of the running channel pulls its pin low at once.
    send_item(make_item(OP_SET_ENABLE, 2'd0, 8'd0, 1'b0));
    send_item(make_item(OP_SET_ENABLE, 2'd0, 8'd0, 1'b1));
    send_item(make_item(OP_QUERY, 2'd3, 8'd255, 1'b1));
    send_item(make_item(OP_SET_ANGLE, 2'd3, 8'd255, 1'b0));
  endtask

  // Limit registers at their extremes, with a minimum above the maximum and
  // writes to indexes past the last register.
  task automatic test_angle_limits();
    int unsigned k;
    settle();
    for (k = int'(REG_MAX_CH3) + 1; k < (1 << CFG_INDEX_W); k++)
      write_reg(CFG_INDEX_W'(k), 8'hFF);
    write_limits('0, '1);
    send_item(make_item(OP_SET_ANGLE, 2'd0, 8'd255, 1'b0));
    send_item(make_item(OP_SET_ANGLE, 2'd1, 8'd0, 1'b1));
    send_item(make_item(OP_SET_ANGLE, 2'd2, 8'd187, 1'b0));
    settle();
    write_limits({NCH{8'd180}}, '0);
    send_item(make_item(OP_SET_ANGLE, 2'd0, 8'd90, 1'b1));
    send_item(make_item(OP_SET_ANGLE, 2'd3, 8'd200, 1'b0));
    settle();
    write_limits('0, {NCH{8'd180}});
    send_item(make_item(OP_SET_ANGLE, 2'd1, 8'd180, 1'b0));
    send_item(make_item(OP_SET_ANGLE, 2'd2, 8'd255, 1'b1));
    send_item(make_item(OP_QUERY, 2'd2, 8'd0, 1'b0));
  endtask

  // The result side holds off for a long stretch while items keep coming.
  task automatic test_output_stall();
    int unsigned k;
    hold_pending = 1'b1;
    for (k = 0; k < 40; k++) send_item(random_item());
  endtask

  task automatic test_random_mix();
    logic [NCH-1:0][ANGLE_W-1:0] lo, hi;
    int unsigned round, k, c;
    for (round = 0; round < 3; round++) begin
      settle();
      for (c = 0; c < NCH; c++) begin
        lo[c] = pick_limit();
        hi[c] = pick_limit();
      end
      write_limits(lo, hi);
      for (k = 0; k < 350; k++) send_item(random_item());
    end
  endtask

  // Whole frames: all slots at saturated width, all slots empty, then empty
  // slots mixed with random widths. Sparse commands land inside each frame.
  task automatic test_frame_sequence();
    int unsigned pattern, c;
    bit          on;
    settle();
    write_limits('0, '1);
    for (pattern = 0; pattern < 3; pattern++) begin
      // One tick first, so that each pattern waits for a frame end of its own.
      send_item(make_item(OP_TICK, 2'd0, 8'd0, 1'b0));
      while (tick_now != FRAME - 1) send_item(frame_item());
      for (c = 0; c < NCH; c++) begin
        case (pattern)
          0:       on = 1'b1;
          1:       on = 1'b0;
          default: on = c[0];
        endcase
        send_item(make_item(OP_SET_ANGLE, CHAN_W'(c),
                            (pattern == 0) ? 8'd255 : ANGLE_W'($urandom_range(0, 255)), 1'b0));
        if (!on) send_item(make_item(OP_SET_ENABLE, CHAN_W'(c), 8'd0, 1'b0));
      end
    end
    // Start the last frame and run it until every slot has ended.
    send_item(make_item(OP_TICK, 2'd0, 8'd0, 1'b0));
    while (slot_now != 0) send_item(frame_item());
  endtask

  // Result side: random stalls, calm stretches and the requested long hold.
  initial begin : result_sink
    int unsigned stall_left, hold_left, calm_left;
    bit          calm;
    stall_left = 0;
    hold_left  = 0;
    calm_left  = 0;
    calm       = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (calm_left == 0) begin
        calm      = !calm;
        calm_left = $urandom_range(50, 500);
      end else begin
        calm_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        stall_left = pick_gap(calm);
        if (stall_left != 0) begin
          stall_left--;
          result_ready <= 1'b0;
        end else begin
          result_ready <= 1'b1;
        end
      end
    end
  end

  // Each result beat is matched against the oldest expected one.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected: %h", $realtime, result);
      end else begin
        exp_r = expected_results.pop_front();
        if (result.pin_levels !== exp_r.pin_levels ||
            result.active_slot !== exp_r.active_slot ||
            result.angle_readback !== exp_r.angle_readback ||
            result.enabled_readback !== exp_r.enabled_readback) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch pins %h/%h slot %0d/%0d angle %0d/%0d enabled %0b/%0b",
                     $realtime, exp_r.pin_levels, result.pin_levels,
                     exp_r.active_slot, result.active_slot,
                     exp_r.angle_readback, result.angle_readback,
                     exp_r.enabled_readback, result.enabled_readback);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[sequential_servo_pulse_scheduler_top] ERROR");
    $finish;
  end

  initial begin
    reset_schedule();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_state();
    test_command_basics();
    test_angle_limits();
    test_output_stall();
    test_random_mix();
    test_frame_sequence();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[sequential_servo_pulse_scheduler_top] OK");
    end else begin
      $display("[sequential_servo_pulse_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule
